// ----- sv/htd_pkg.sv -----
// Shared types and constants for the Huffman trie decoder.
`timescale 1ns / 1ps
package htd_pkg;

   localparam int NODE_COUNT    = 512;
   localparam int MAX_CODE_BITS = 32;
   localparam int BYTE_BITS     = 8;

   localparam int NODE_W = $clog2(NODE_COUNT);
   localparam int USED_W = $clog2(NODE_COUNT + 1);
   localparam int CNT_W  = $clog2(MAX_CODE_BITS + 1);
   localparam int DBIT_W = $clog2(BYTE_BITS + 1);

   typedef struct packed {
      logic [NODE_W-1:0] kid_one;
      logic [NODE_W-1:0] kid_zero;
      logic              leaf;
      logic [7:0]        value;
   } node_type;

   localparam int NODE_BITS = $bits(node_type);

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_DATA  = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALIGN,
      ST_LBIT,
      ST_LCAP,
      ST_DSTEP,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic [7:0] symbol;
      logic       is_symbol;
      logic       last;
      logic       done;
      logic       error;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type beat;
   } push_type;

endpackage

// ----- sv/htd_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module htd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/htd_rsp_reg.sv -----
// Output register of the result channel.
`timescale 1ns / 1ps
module htd_rsp_reg (
   input  logic              clock,
   input  logic              reset,
   input  htd_pkg::push_type push,
   output logic              free,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_out_symbol,
   output logic              rsp_is_symbol,
   output logic              rsp_last,
   output logic              rsp_done_res,
   output logic              rsp_error
);

   logic             valid_ff;
   logic             valid_in;
   htd_pkg::rsp_type beat_ff;

   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (push.valid && free) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // load a new beat only when the slot is empty or draining
   always_ff @(posedge clock) begin
      if (push.valid && free) begin
         beat_ff <= push.beat;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_symbol = beat_ff.symbol;
   assign rsp_is_symbol  = beat_ff.is_symbol;
   assign rsp_last       = beat_ff.last;
   assign rsp_done_res   = beat_ff.done;
   assign rsp_error      = beat_ff.error;

endmodule

// ----- sv/huffman_trie_decoder.sv -----
// Huffman decoder over a code tree kept in a node RAM, one code bit per step.
//
//   channel | direction | handshake          | beat
//   req_    | in        | req_valid/ready    | cmd, symbol, code_length, code_bits, data_byte
//   rsp_    | out       | rsp_valid/ready    | out_symbol, is_symbol, last, done_res, error
//   csr_    | in        | csr_valid/ready    | symbol_total
//
// Clear, unknown command, rejected load and ignored data byte go straight to the status beat.
// Load first lines up the code in its shift register, then walks it, adding each new node or
// reading each existing node from the node RAM. A data byte is walked bit by bit; each decoded
// symbol is sent, and a status beat follows the symbols when both end the item.
// No clearing pass after reset: the root is kept in a register. A result held on rsp_ stalls
// the walk; req_ready is high only between items.
`timescale 1ns / 1ps
module huffman_trie_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_symbol,
   input  logic [5:0]  req_code_length,
   input  logic [31:0] req_code_bits,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_symbol,
   output logic        rsp_is_symbol,
   output logic        rsp_last,
   output logic        rsp_done_res,
   output logic        rsp_error,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_symbol_total
);

   localparam int NW = htd_pkg::NODE_W;
   localparam int UW = htd_pkg::USED_W;
   localparam int CW = htd_pkg::CNT_W;
   localparam int DW = htd_pkg::DBIT_W;
   localparam int MB = htd_pkg::MAX_CODE_BITS;

   htd_pkg::state_type state_ff, state_in;

   // control state
   logic [NW-1:0]      walk_ff, walk_in;
   logic [31:0]        count_ff, count_in;
   logic [UW-1:0]      used_ff, used_in;
   htd_pkg::node_type  root_ff, root_in;
   logic [31:0]        total_ff;
   logic               pend_valid_ff, pend_valid_in;

   // payload state
   logic [7:0]         pend_sym_ff, pend_sym_in;
   logic               pend_done_ff, pend_done_in;
   logic               need_status_ff, need_status_in;
   logic               err_ff, err_in;
   logic [MB-1:0]      code_ff, code_in;
   logic [CW-1:0]      lbits_ff, lbits_in;
   logic [CW-1:0]      skip_ff, skip_in;
   logic [NW-1:0]      cur_ff, cur_in;
   htd_pkg::node_type  ent_ff, ent_in;
   logic [7:0]         sym_ff, sym_in;
   logic [7:0]         byte_ff, byte_in;
   logic [DW-1:0]      dbits_ff, dbits_in;
   logic               step_ff, step_in;

   // node RAM port
   logic                          wr_en;
   logic [NW-1:0]                 wr_addr;
   htd_pkg::node_type             wr_node;
   logic                          rd_en;
   logic [NW-1:0]                 rd_addr;
   logic [htd_pkg::NODE_BITS-1:0] rd_data;
   htd_pkg::node_type             ram_q;

   htd_pkg::push_type push;
   logic              out_free;

   // shared conditions
   logic              acc;
   htd_pkg::cmd_type  cmd;
   logic              len_bad;
   logic [CW-1:0]     skip_start;
   logic              is_done;
   logic [31:0]       count_nx;
   htd_pkg::node_type d_ent;
   logic              d_leaf;
   logic [NW-1:0]     d_kid;
   logic [NW-1:0]     l_kid;
   logic              full;
   logic              emit_ok;

   htd_ram #(
      .WIDTH (htd_pkg::NODE_BITS),
      .DEPTH (htd_pkg::NODE_COUNT)
   ) u_nodes (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_node),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   htd_rsp_reg u_rsp (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .free           (out_free),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_symbol (rsp_out_symbol),
      .rsp_is_symbol  (rsp_is_symbol),
      .rsp_last       (rsp_last),
      .rsp_done_res   (rsp_done_res),
      .rsp_error      (rsp_error)
   );

   assign ram_q     = htd_pkg::node_type'(rd_data);
   assign req_ready = (state_ff == htd_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign acc       = req_valid && req_ready;
   assign cmd       = htd_pkg::cmd_type'(req_cmd);

   assign len_bad    = (req_code_length == 6'd0) || (int'(req_code_length) > MB);
   assign skip_start = CW'(MB - int'(req_code_length));
   assign is_done    = (count_ff >= total_ff);
   assign count_nx   = count_ff + 32'd1;

   // the root lives in a register; every other node comes from the RAM
   assign d_ent   = (walk_ff == '0) ? root_ff : ram_q;
   // a leaf counts only on arrival, not when the walk rests on it between beats
   assign d_leaf  = step_ff && d_ent.leaf;
   assign d_kid   = byte_ff[7] ? d_ent.kid_one : d_ent.kid_zero;
   assign l_kid   = code_ff[MB-1] ? ent_ff.kid_one : ent_ff.kid_zero;
   assign full    = (used_ff >= UW'(htd_pkg::NODE_COUNT));
   assign emit_ok = !pend_valid_ff || out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         htd_pkg::ST_IDLE: begin
            if (acc) begin
               case (cmd)
                  htd_pkg::CMD_LOAD: begin
                     if (len_bad) begin
                        state_in = htd_pkg::ST_FIN;
                     end else if (skip_start != '0) begin
                        state_in = htd_pkg::ST_ALIGN;
                     end else begin
                        state_in = htd_pkg::ST_LBIT;
                     end
                  end
                  htd_pkg::CMD_DATA: begin
                     state_in = is_done ? htd_pkg::ST_FIN : htd_pkg::ST_DSTEP;
                  end
                  default: begin
                     state_in = htd_pkg::ST_FIN;
                  end
               endcase
            end
         end
         htd_pkg::ST_ALIGN: begin
            if (skip_ff == CW'(1)) begin
               state_in = htd_pkg::ST_LBIT;
            end
         end
         htd_pkg::ST_LBIT: begin
            if (lbits_ff == '0) begin
               state_in = htd_pkg::ST_FIN;
            end else if (l_kid != '0) begin
               state_in = htd_pkg::ST_LCAP;
            end else if (full) begin
               state_in = htd_pkg::ST_FIN;
            end
         end
         htd_pkg::ST_LCAP: begin
            state_in = htd_pkg::ST_LBIT;
         end
         htd_pkg::ST_DSTEP: begin
            if (!d_leaf) begin
               if (is_done || dbits_ff == '0 || d_kid == '0) begin
                  state_in = htd_pkg::ST_FIN;
               end
            end
         end
         htd_pkg::ST_FIN: begin
            if (out_free && !(pend_valid_ff && need_status_ff)) begin
               state_in = htd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = htd_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath, RAM port and result pushes
   always_comb begin
      walk_in        = walk_ff;
      count_in       = count_ff;
      used_in        = used_ff;
      root_in        = root_ff;
      pend_valid_in  = pend_valid_ff;
      pend_sym_in    = pend_sym_ff;
      pend_done_in   = pend_done_ff;
      need_status_in = need_status_ff;
      err_in         = err_ff;
      code_in        = code_ff;
      lbits_in       = lbits_ff;
      skip_in        = skip_ff;
      cur_in         = cur_ff;
      ent_in         = ent_ff;
      sym_in         = sym_ff;
      byte_in        = byte_ff;
      dbits_in       = dbits_ff;
      step_in        = step_ff;
      wr_en          = 1'b0;
      wr_addr        = cur_ff;
      wr_node        = ent_ff;
      rd_en          = 1'b0;
      rd_addr        = walk_ff;
      push           = '0;

      case (state_ff)
         htd_pkg::ST_IDLE: begin
            // keep the walk node's entry ready for the next data beat
            rd_en = 1'b1;
            if (acc) begin
               need_status_in = 1'b1;
               err_in         = 1'b0;
               step_in        = 1'b0;
               case (cmd)
                  htd_pkg::CMD_CLEAR: begin
                     root_in  = '0;
                     used_in  = UW'(1);
                     walk_in  = '0;
                     count_in = '0;
                  end
                  htd_pkg::CMD_LOAD: begin
                     err_in   = len_bad;
                     code_in  = MB'(req_code_bits);
                     lbits_in = CW'(req_code_length);
                     skip_in  = skip_start;
                     cur_in   = '0;
                     ent_in   = root_ff;
                     sym_in   = req_symbol;
                  end
                  htd_pkg::CMD_DATA: begin
                     byte_in  = req_data_byte;
                     dbits_in = DW'(htd_pkg::BYTE_BITS);
                  end
                  default: begin
                     err_in = 1'b0;
                  end
               endcase
            end
         end
         htd_pkg::ST_ALIGN: begin
            code_in = code_ff << 1;
            skip_in = skip_ff - CW'(1);
         end
         htd_pkg::ST_LBIT: begin
            if (lbits_ff == '0) begin
               wr_en         = 1'b1;
               wr_node       = ent_ff;
               wr_node.leaf  = 1'b1;
               wr_node.value = sym_ff;
            end else if (l_kid != '0) begin
               rd_en    = 1'b1;
               rd_addr  = l_kid;
               cur_in   = l_kid;
               code_in  = code_ff << 1;
               lbits_in = lbits_ff - CW'(1);
            end else if (full) begin
               // write back the current node so a fresh one is never left unwritten
               wr_en  = 1'b1;
               err_in = 1'b1;
            end else begin
               wr_en = 1'b1;
               if (code_ff[MB-1]) begin
                  wr_node.kid_one = used_ff[NW-1:0];
               end else begin
                  wr_node.kid_zero = used_ff[NW-1:0];
               end
               used_in  = used_ff + UW'(1);
               cur_in   = used_ff[NW-1:0];
               ent_in   = '0;
               code_in  = code_ff << 1;
               lbits_in = lbits_ff - CW'(1);
            end
         end
         htd_pkg::ST_LCAP: begin
            ent_in = ram_q;
         end
         htd_pkg::ST_DSTEP: begin
            if (d_leaf) begin
               // hold the symbol until it is known whether it ends the item
               if (emit_ok) begin
                  if (pend_valid_ff) begin
                     push.valid          = 1'b1;
                     push.beat.symbol    = pend_sym_ff;
                     push.beat.is_symbol = 1'b1;
                     push.beat.done      = pend_done_ff;
                  end
                  pend_valid_in = 1'b1;
                  pend_sym_in   = d_ent.value;
                  pend_done_in  = (count_nx >= total_ff);
                  count_in      = count_nx;
                  walk_in       = '0;
                  step_in       = 1'b0;
               end
            end else if (is_done || dbits_ff == '0) begin
               need_status_in = !pend_valid_ff;
            end else if (d_kid == '0) begin
               walk_in = '0;
               err_in  = 1'b1;
            end else begin
               walk_in  = d_kid;
               rd_en    = 1'b1;
               rd_addr  = d_kid;
               byte_in  = byte_ff << 1;
               dbits_in = dbits_ff - DW'(1);
               step_in  = 1'b1;
            end
         end
         htd_pkg::ST_FIN: begin
            if (out_free) begin
               push.valid = 1'b1;
               if (pend_valid_ff) begin
                  push.beat.symbol    = pend_sym_ff;
                  push.beat.is_symbol = 1'b1;
                  push.beat.last      = !need_status_ff;
                  push.beat.done      = pend_done_ff;
                  pend_valid_in       = 1'b0;
               end else begin
                  push.beat.last  = 1'b1;
                  push.beat.done  = is_done;
                  push.beat.error = err_ff;
               end
            end
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase

      // mirror root writes into the root register
      if (wr_en && wr_addr == '0) begin
         root_in = wr_node;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= htd_pkg::ST_IDLE;
         walk_ff       <= '0;
         count_ff      <= '0;
         used_ff       <= UW'(1);
         root_ff       <= '0;
         total_ff      <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         walk_ff       <= walk_in;
         count_ff      <= count_in;
         used_ff       <= used_in;
         root_ff       <= root_in;
         pend_valid_ff <= pend_valid_in;
         if (csr_valid && csr_ready) begin
            total_ff <= csr_symbol_total;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_sym_ff    <= pend_sym_in;
      pend_done_ff   <= pend_done_in;
      need_status_ff <= need_status_in;
      err_ff         <= err_in;
      code_ff        <= code_in;
      lbits_ff       <= lbits_in;
      skip_ff        <= skip_in;
      cur_ff         <= cur_in;
      ent_ff         <= ent_in;
      sym_ff         <= sym_in;
      byte_ff        <= byte_in;
      dbits_ff       <= dbits_in;
      step_ff        <= step_in;
   end

endmodule

// ----- tb/huffman_trie_decoder_checker.sv -----
// Scoreboard for the Huffman trie decoder: predicts every result beat and compares it.
`timescale 1ns / 1ps
module huffman_trie_decoder_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_symbol,
   input  logic [5:0]  req_code_length,
   input  logic [31:0] req_code_bits,
   input  logic [7:0]  req_data_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_out_symbol,
   input  logic        rsp_is_symbol,
   input  logic        rsp_last,
   input  logic        rsp_done_res,
   input  logic        rsp_error,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [31:0] csr_symbol_total,
   output int          fail_count,
   output int          pending_count
);

   localparam int NW = htd_pkg::NODE_W;
   localparam int UW = htd_pkg::USED_W;

   htd_pkg::node_type tree [htd_pkg::NODE_COUNT];
   logic [UW-1:0]     nodes_alloc;
   logic [NW-1:0]     walk_at;
   logic [31:0]       symbols_out;
   logic [31:0]       symbol_goal;
   htd_pkg::rsp_type  awaited [$];
   int                fails = 0;

   task automatic restart_tree();
      tree[0]     = '0;
      nodes_alloc = UW'(1);
      walk_at     = '0;
      symbols_out = '0;
   endtask

   function automatic htd_pkg::rsp_type status(input logic [7:0] sym, input logic is_sym,
                                               input logic err);
      htd_pkg::rsp_type r;
      r.symbol    = sym;
      r.is_symbol = is_sym;
      r.last      = 1'b0;
      r.done      = (symbols_out >= symbol_goal);
      r.error     = err;
      return r;
   endfunction

   // Walk the code MSB first, allocate missing nodes, mark the end node a leaf.
   task automatic insert_code(input logic [5:0] len, input logic [31:0] bits,
                              input logic [7:0] sym, output logic err);
      logic [NW-1:0] cur;
      logic [NW-1:0] nxt;
      logic          b;
      int            i;
      err = (len == 0 || len > htd_pkg::MAX_CODE_BITS);
      cur = '0;
      for (i = len; i > 0 && !err; i--) begin
         b   = bits[i-1];
         nxt = b ? tree[cur].kid_one : tree[cur].kid_zero;
         if (nxt == '0) begin
            if (nodes_alloc >= htd_pkg::NODE_COUNT) begin
               err = 1'b1;
            end else begin
               nxt         = nodes_alloc[NW-1:0];
               nodes_alloc = nodes_alloc + UW'(1);
               tree[nxt]   = '0;
               if (b) tree[cur].kid_one = nxt;
               else tree[cur].kid_zero = nxt;
            end
         end
         cur = nxt;
      end
      if (!err) begin
         tree[cur].leaf  = 1'b1;
         tree[cur].value = sym;
      end
   endtask

   task automatic predict(input logic [1:0] cmd, input logic [7:0] sym,
                          input logic [5:0] len, input logic [31:0] bits,
                          input logic [7:0] dbyte);
      htd_pkg::rsp_type res [8];
      int               n;
      int               pos;
      int               i;
      logic             err;
      logic             b;
      logic             stop;
      logic [NW-1:0]    nxt;
      n   = 0;
      err = 1'b0;
      case (cmd)
         htd_pkg::CMD_CLEAR: begin
            restart_tree();
            res[n] = status(8'd0, 1'b0, 1'b0);
            n++;
         end
         htd_pkg::CMD_LOAD: begin
            insert_code(len, bits, sym, err);
            res[n] = status(8'd0, 1'b0, err);
            n++;
         end
         htd_pkg::CMD_DATA: begin
            stop = 1'b0;
            for (pos = 7; pos >= 0 && !stop; pos--) begin
               if (symbols_out >= symbol_goal) begin
                  stop = 1'b1;
               end else begin
                  b   = dbyte[pos];
                  nxt = b ? tree[walk_at].kid_one : tree[walk_at].kid_zero;
                  if (nxt == '0) begin
                     // missing child: back to the root, drop the rest of the byte
                     err     = 1'b1;
                     walk_at = '0;
                     stop    = 1'b1;
                  end else begin
                     walk_at = nxt;
                     if (tree[walk_at].leaf) begin
                        symbols_out = symbols_out + 32'd1;
                        res[n] = status(tree[walk_at].value, 1'b1, 1'b0);
                        n++;
                        walk_at = '0;
                     end
                  end
               end
            end
            if (err || n == 0) begin
               res[n] = status(8'd0, 1'b0, err);
               n++;
            end
         end
         default: begin
            res[n] = status(8'd0, 1'b0, 1'b0);
            n++;
         end
      endcase
      res[n-1].last = 1'b1;
      for (i = 0; i < n; i++) awaited = {awaited, res[i]};
   endtask

   task automatic cmp_field(input string name, input logic [7:0] want,
                            input logic [7:0] got, inout bit bad);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         bad = 1'b1;
      end
   endtask

   always @(posedge clock) begin : watch
      htd_pkg::rsp_type got;
      htd_pkg::rsp_type want;
      bit               bad;
      if (reset) begin
         symbol_goal = '0;
         restart_tree();
         awaited.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_out_symbol, rsp_is_symbol, rsp_last, rsp_done_res, rsp_error};
            if (awaited.size() == 0) begin
               $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
               fails++;
            end else begin
               want = awaited.pop_front();
               bad  = 1'b0;
               cmp_field("out_symbol", want.symbol, got.symbol, bad);
               cmp_field("is_symbol", 8'(want.is_symbol), 8'(got.is_symbol), bad);
               cmp_field("last", 8'(want.last), 8'(got.last), bad);
               cmp_field("done_res", 8'(want.done), 8'(got.done), bad);
               cmp_field("error", 8'(want.error), 8'(got.error), bad);
               if (bad) fails++;
            end
         end
         if (csr_valid && csr_ready) symbol_goal = csr_symbol_total;
         if (req_valid && req_ready)
            predict(req_cmd, req_symbol, req_code_length, req_code_bits, req_data_byte);
      end
      fail_count    <= fails;
      pending_count <= awaited.size();
   end

endmodule

// ----- tb/huffman_trie_decoder_tb.sv -----
// Stimulus, handshake pacing and verdict for the Huffman trie decoder.
`timescale 1ns / 1ps
module huffman_trie_decoder_tb;

   localparam logic [1:0] CMD_UNKNOWN = 2'd3;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 150;
   localparam int STALL_LIMIT  = 5000;
   localparam int PHASES       = 8;

   typedef struct packed {
      logic [5:0]  len;
      logic [31:0] code;
   } code_word_type;

   logic        clock;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_ready;
   logic [1:0]  req_cmd          = htd_pkg::CMD_CLEAR;
   logic [7:0]  req_symbol       = '0;
   logic [5:0]  req_code_length  = '0;
   logic [31:0] req_code_bits    = '0;
   logic [7:0]  req_data_byte    = '0;
   logic        rsp_valid;
   logic        rsp_ready        = 1'b0;
   logic [7:0]  rsp_out_symbol;
   logic        rsp_is_symbol;
   logic        rsp_last;
   logic        rsp_done_res;
   logic        rsp_error;
   logic        csr_valid        = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_symbol_total = '0;

   int            fail_count;
   int            pending_count;
   bit            quiet    = 1'b0;
   bit            hold_req = 1'b0;
   code_word_type code_set [$];

   huffman_trie_decoder u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_symbol       (req_symbol),
      .req_code_length  (req_code_length),
      .req_code_bits    (req_code_bits),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_symbol   (rsp_out_symbol),
      .rsp_is_symbol    (rsp_is_symbol),
      .rsp_last         (rsp_last),
      .rsp_done_res     (rsp_done_res),
      .rsp_error        (rsp_error),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_symbol_total (csr_symbol_total)
   );

   huffman_trie_decoder_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_symbol       (req_symbol),
      .req_code_length  (req_code_length),
      .req_code_bits    (req_code_bits),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_symbol   (rsp_out_symbol),
      .rsp_is_symbol    (rsp_is_symbol),
      .rsp_last         (rsp_last),
      .rsp_done_res     (rsp_done_res),
      .rsp_error        (rsp_error),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_symbol_total (csr_symbol_total),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic send(input logic [1:0] cmd, input logic [7:0] sym, input logic [5:0] len,
                       input logic [31:0] bits, input logic [7:0] dbyte);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_symbol      <= sym;
      req_code_length <= len;
      req_code_bits   <= bits;
      req_data_byte   <= dbyte;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_load(input logic [7:0] sym, input logic [5:0] len,
                            input logic [31:0] bits);
      send(htd_pkg::CMD_LOAD, sym, len, bits, 8'($urandom));
   endtask

   task automatic send_data(input logic [7:0] dbyte);
      send(htd_pkg::CMD_DATA, 8'($urandom), 6'($urandom), $urandom, dbyte);
   endtask

   task automatic send_noise();
      send(2'($urandom), 8'($urandom), 6'($urandom), $urandom, 8'($urandom));
   endtask

   // Drop valid and wait until every expected beat is in and the block has gone quiet.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_total(input logic [31:0] total);
      settle();
      csr_valid        <= 1'b1;
      csr_symbol_total <= total;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Replace one leaf of the code set by its two children, in random order.
   task automatic split_code(input int idx);
      code_word_type cw;
      code_word_type c0;
      code_word_type c1;
      cw = code_set[idx];
      code_set.delete(idx);
      c0 = {cw.len + 6'd1, cw.code << 1};
      c1 = {cw.len + 6'd1, (cw.code << 1) | 32'd1};
      if ($urandom_range(0, 1) == 0) begin
         code_set = {code_set, c0, c1};
      end else begin
         code_set = {code_set, c1, c0};
      end
   endtask

   initial begin : receiver
      bit held;
      held = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_req && !held) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            idle = 0;
         else
            idle++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      int            ph;
      int            n;
      int            idx;
      int            target;
      int            chain_len;
      logic [31:0]   total;
      code_word_type cw;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Count already at the reset goal of zero: the byte is ignored.
      send_data(8'h00);
      write_total(32'hFFFF_FFFF);
      send_load(8'h11, 6'd0, $urandom);
      send_load(8'h12, 6'd33, $urandom);
      send_load(8'h13, 6'd63, $urandom);
      // A = 0, B = 10, C = 11; junk above the code length must be ignored
      send_load(8'h41, 6'd1, 32'hFFFF_FFFE);
      send_load(8'h42, 6'd2, 32'h0000_0002);
      send_load(8'h43, 6'd2, 32'hA5A5_A5A7);
      send_data(8'h00);
      send_data(8'hFF);
      send_data(8'h96);
      send(CMD_UNKNOWN, 8'hFF, 6'h3F, 32'hFFFF_FFFF, 8'hFF);
      // longest code runs through the leaf at 11
      send_load(8'hFF, 6'd32, 32'hFFFF_FFFF);
      // leave the walk resting on the inner node at 1
      send_data(8'h01);
      // code ending on an inner node turns it into a leaf
      send_load(8'h80, 6'd1, 32'h0000_0001);
      send_data(8'hC0);
      send(htd_pkg::CMD_CLEAR, 8'($urandom), 6'($urandom), $urandom, 8'($urandom));
      send_load(8'h10, 6'd2, 32'h0000_0000);
      send_data(8'h40);
      send_data(8'h00);
      send_data(8'h20);
      // goal lowered below the count already decoded
      write_total(32'd3);
      send_data(8'h00);
      send(htd_pkg::CMD_CLEAR, 8'h00, 6'd0, 32'd0, 8'h00);
      send_load(8'h10, 6'd2, 32'h0000_0000);
      send_data(8'h00);
      send_data(8'h00);

      for (ph = 0; ph < PHASES; ph++) begin
         if (ph == 0) begin
            total = 32'hFFFF_FFFF;
         end else if (ph == 1) begin
            total = 32'd0;
         end else begin
            case ($urandom_range(0, 4))
               0: total = 32'hFFFF_FFFF;
               1: total = 32'd0;
               2: total = 32'd1;
               3: total = $urandom_range(1, 40);
               default: total = $urandom;
            endcase
         end
         write_total(total);
         quiet <= (ph >= PHASES - 2);
         if (ph == 2) hold_req <= 1'b1;

         if (ph == 4) begin
            // long codes until the node store runs out
            send(htd_pkg::CMD_CLEAR, 8'($urandom), 6'($urandom), $urandom, 8'($urandom));
            repeat (22) send_load(8'($urandom), 6'($urandom_range(24, 32)), $urandom);
            repeat (6) send_data(8'($urandom));
         end else if (ph > 2 && $urandom_range(0, 5) == 0) begin
            repeat (15) send_noise();
         end else begin
            // random complete prefix code, sometimes with one deep branch or a hole
            cw       = '0;
            code_set = {cw};
            target = $urandom_range(2, 12);
            while (code_set.size() < target) begin
               idx = $urandom_range(0, code_set.size() - 1);
               if (code_set[idx].len < 8) split_code(idx);
            end
            if ($urandom_range(0, 3) == 0) begin
               chain_len = $urandom_range(12, 32);
               while (code_set[code_set.size() - 1].len < chain_len)
                  split_code(code_set.size() - 1);
            end
            if ($urandom_range(0, 2) == 0)
               code_set.delete($urandom_range(0, code_set.size() - 1));
            send(htd_pkg::CMD_CLEAR, 8'($urandom), 6'($urandom), $urandom, 8'($urandom));
            while (code_set.size() > 0) begin
               idx = $urandom_range(0, code_set.size() - 1);
               cw  = code_set[idx];
               code_set.delete(idx);
               send_load(8'($urandom), cw.len, cw.code | ($urandom << cw.len));
            end
            n = $urandom_range(6, 14);
            repeat (n) begin
               if ($urandom_range(0, 9) == 0) send_noise();
               else send_data(8'($urandom));
            end
         end
      end

      settle();
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ----- files.f -----
sv/htd_pkg.sv
sv/htd_ram.sv
sv/htd_rsp_reg.sv
sv/huffman_trie_decoder.sv
tb/huffman_trie_decoder_checker.sv
tb/huffman_trie_decoder_tb.sv
